@@ sv/ihex_pkg.sv @@
// Shared types and constants for the Intel HEX record decoder.
// Holds the result record, the address base mode and the hex digit decoder.
// No dependencies.
package ihex_pkg;

  // ASCII codes the decoder looks at
  localparam logic [7:0] CHAR_COLON = 8'h3A;
  localparam logic [7:0] CHAR_0     = 8'h30;
  localparam logic [7:0] CHAR_9     = 8'h39;
  localparam logic [7:0] CHAR_UA    = 8'h41;
  localparam logic [7:0] CHAR_UF    = 8'h46;
  localparam logic [7:0] CHAR_LA    = 8'h61;
  localparam logic [7:0] CHAR_LF    = 8'h66;
  localparam logic [7:0] HEX_TEN    = 8'd10;

  // Record types
  localparam logic [7:0] REC_DATA    = 8'h00;
  localparam logic [7:0] REC_SEGMENT = 8'h02;
  localparam logic [7:0] REC_LINEAR  = 8'h04;

  // Result kinds
  localparam logic KIND_DATA = 1'b0;
  localparam logic KIND_END  = 1'b1;

  // Header byte positions within a record
  localparam logic [8:0] IDX_COUNT   = 9'd0;
  localparam logic [8:0] IDX_OFS_HI  = 9'd1;
  localparam logic [8:0] IDX_OFS_LO  = 9'd2;
  localparam logic [8:0] IDX_TYPE    = 9'd3;
  localparam logic [8:0] IDX_DATA    = 9'd4;

  typedef enum logic [1:0] {
    BASE_NONE    = 2'd0,
    BASE_SEGMENT = 2'd1,
    BASE_LINEAR  = 2'd2
  } base_mode_t;

  typedef struct packed {
    logic        kind;
    logic [7:0]  data_byte;
    logic [31:0] abs_address;
    logic [7:0]  byte_count;
    logic [7:0]  record_type;
    logic        checksum_ok;
    logic        error;
  } result_t;

  typedef struct packed {
    logic       ok;
    logic [3:0] nib;
  } hex_t;

  function automatic hex_t hex_decode(input logic [7:0] c);
    hex_t h;
    h.ok  = 1'b1;
    h.nib = '0;
    if (c inside {[CHAR_0:CHAR_9]}) begin
      h.nib = 4'(c - CHAR_0);
    end else if (c inside {[CHAR_UA:CHAR_UF]}) begin
      h.nib = 4'(c - CHAR_UA + HEX_TEN);
    end else if (c inside {[CHAR_LA:CHAR_LF]}) begin
      h.nib = 4'(c - CHAR_LA + HEX_TEN);
    end else begin
      h.ok = 1'b0;
    end
    return h;
  endfunction

endpackage

@@ sv/ihex_parser.sv @@
// Record parser: state registers and the per-character decode step.
// Depends on ihex_pkg for the result type, base modes and hex decoding.
module ihex_parser
  import ihex_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       step,
  input  logic [7:0] char_q,
  output logic       res_valid,
  output result_t    res
);

  logic        in_record_r, in_record_nxt;
  logic [9:0]  pos_r, pos_nxt;
  logic [3:0]  high_r, high_nxt;
  logic [7:0]  count_r, count_nxt;
  logic [15:0] offset_r, offset_nxt;
  logic [7:0]  type_r, type_nxt;
  logic [15:0] base_value_r, base_value_nxt;
  base_mode_t  base_mode_r, base_mode_nxt;
  logic [7:0]  sum_r, sum_nxt;
  logic [15:0] pending_r, pending_nxt;

  hex_t        hex;
  logic [7:0]  byte_val;
  logic [8:0]  idx;
  logic [8:0]  data_end;
  logic [8:0]  data_i;
  logic [31:0] start_addr;

  assign hex      = hex_decode(char_q);
  assign byte_val = {high_r, hex.nib};
  assign idx      = pos_r[9:1];
  assign data_end = 9'(count_r) + IDX_DATA;
  assign data_i   = idx - IDX_DATA;

  always_comb begin
    case (base_mode_r)
      BASE_SEGMENT: start_addr = {12'h000, base_value_r, 4'h0} + {16'h0000, offset_r};
      BASE_LINEAR:  start_addr = {base_value_r, offset_r};
      default:      start_addr = {16'h0000, offset_r};
    endcase
  end

  always_comb begin
    in_record_nxt  = in_record_r;
    pos_nxt        = pos_r;
    high_nxt       = high_r;
    count_nxt      = count_r;
    offset_nxt     = offset_r;
    type_nxt       = type_r;
    base_value_nxt = base_value_r;
    base_mode_nxt  = base_mode_r;
    sum_nxt        = sum_r;
    pending_nxt    = pending_r;
    res_valid      = 1'b0;
    res.kind        = KIND_DATA;
    res.data_byte   = '0;
    res.abs_address = start_addr;
    res.byte_count  = count_r;
    res.record_type = type_r;
    res.checksum_ok = 1'b0;
    res.error       = 1'b0;

    if (step) begin
      if (!in_record_r) begin
        // open a record on a colon, drop everything else
        if (char_q == CHAR_COLON) begin
          in_record_nxt = 1'b1;
          pos_nxt       = '0;
          high_nxt      = '0;
          count_nxt     = '0;
          offset_nxt    = '0;
          type_nxt      = '0;
          sum_nxt       = '0;
          pending_nxt   = '0;
        end
      end else if (!hex.ok) begin
        in_record_nxt = 1'b0;
        res_valid     = 1'b1;
        res.kind      = KIND_END;
        res.error     = 1'b1;
      end else if (!pos_r[0]) begin
        high_nxt = hex.nib;
        pos_nxt  = pos_r + 10'd1;
      end else begin
        pos_nxt = pos_r + 10'd1;
        sum_nxt = sum_r + byte_val;
        if (idx == IDX_COUNT) begin
          count_nxt = byte_val;
        end else if (idx == IDX_OFS_HI) begin
          offset_nxt = {byte_val, offset_r[7:0]};
        end else if (idx == IDX_OFS_LO) begin
          offset_nxt = {offset_r[15:8], byte_val};
        end else if (idx == IDX_TYPE) begin
          type_nxt = byte_val;
        end else if (idx < data_end) begin
          if (data_i == 9'd0) begin
            pending_nxt = {byte_val, 8'h00};
          end else if (data_i == 9'd1) begin
            pending_nxt = {pending_r[15:8], byte_val};
          end
          if (type_r == REC_DATA) begin
            res_valid       = 1'b1;
            res.data_byte   = byte_val;
            res.abs_address = start_addr + 32'(data_i);
          end
        end else begin
          // checksum byte closes the record
          in_record_nxt   = 1'b0;
          res_valid       = 1'b1;
          res.kind        = KIND_END;
          res.checksum_ok = (sum_nxt == 8'h00);
          if (sum_nxt == 8'h00 && type_r == REC_SEGMENT) begin
            base_value_nxt = pending_r;
            base_mode_nxt  = BASE_SEGMENT;
          end else if (sum_nxt == 8'h00 && type_r == REC_LINEAR) begin
            base_value_nxt = pending_r;
            base_mode_nxt  = BASE_LINEAR;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_record_r  <= 1'b0;
      pos_r        <= '0;
      high_r       <= '0;
      count_r      <= '0;
      offset_r     <= '0;
      type_r       <= '0;
      base_value_r <= '0;
      base_mode_r  <= BASE_NONE;
      sum_r        <= '0;
      pending_r    <= '0;
    end else begin
      in_record_r  <= in_record_nxt;
      pos_r        <= pos_nxt;
      high_r       <= high_nxt;
      count_r      <= count_nxt;
      offset_r     <= offset_nxt;
      type_r       <= type_nxt;
      base_value_r <= base_value_nxt;
      base_mode_r  <= base_mode_nxt;
      sum_r        <= sum_nxt;
      pending_r    <= pending_nxt;
    end
  end

`ifndef SYNTHESIS
  a_data_keeps_record_open: assert property (@(posedge clk) disable iff (!rst_n)
    step && res_valid && res.kind == KIND_DATA |=> in_record_r)
    else $error("data result closed the record");

  a_end_closes_record: assert property (@(posedge clk) disable iff (!rst_n)
    step && res_valid && res.kind == KIND_END |=> !in_record_r)
    else $error("end result left the record open");

  a_base_changes_at_end: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) && base_mode_r != $past(base_mode_r)
    |-> $past(step && res_valid && res.kind == KIND_END && res.checksum_ok))
    else $error("base mode changed outside a good record end");
`endif

endmodule

@@ sv/ihex_result_reg.sv @@
// Result register: holds one decoded result until the consumer takes it.
// Depends on ihex_pkg for the result type.
module ihex_result_reg
  import ihex_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    load,
  input  result_t res,
  input  logic    out_stall,
  output logic    out_valid,
  output result_t out_res
);

  logic    valid_r, valid_nxt;
  result_t res_r;

  always_comb begin
    if (load) begin
      valid_nxt = 1'b1;
    end else if (!out_stall) begin
      valid_nxt = 1'b0;
    end else begin
      valid_nxt = valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res;
    end
  end

  assign out_valid = valid_r;
  assign out_res   = res_r;

endmodule

@@ sv/intel_hex_record_decoder.sv @@
// Intel HEX record decoder top level: input register, parser, result register.
// Depends on ihex_pkg, ihex_parser and ihex_result_reg.
//
// Feed the ASCII text of an Intel HEX file one character per transaction. A
// colon opens a record; characters outside a record are dropped silently.
// Each data byte of a type 0 record comes out as a kind 0 transaction with
// its absolute address (no base: offset; after a type 2 record: base*16 +
// offset; after a type 4 record: base<<16 | offset; plus the byte's index).
// The checksum digit, or any non-hex character inside a record, produces a
// kind 1 transaction carrying the checksum verdict and error flag, so drop
// the preceding bytes of a record whose end says checksum_ok = 0. Type 2 and
// type 4 records load the address base only when their checksum is good.
// Throughput is one character per clock while the output is not stalled: a
// character is held in the input register, the parser state updates while
// it is held there, and its result is registered in the output register,
// which raises out_valid. The single output register sets the rate under
// backpressure: a character advances only while that register is empty or
// being emptied.
module intel_hex_record_decoder
  import ihex_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_char_in,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_kind,
  output logic [7:0]  out_data_byte,
  output logic [31:0] out_abs_address,
  output logic [7:0]  out_byte_count,
  output logic [7:0]  out_record_type,
  output logic        out_checksum_ok,
  output logic        out_error
);

  logic       s1_valid_r, s1_valid_nxt;
  logic [7:0] s1_char_r;
  logic       in_accept;
  logic       advance;
  logic       res_valid;
  result_t    res;
  result_t    out_res;

  // Advance the held character when the output slot is free or draining.
  assign advance   = s1_valid_r && (!out_valid || !out_stall);
  assign in_stall  = s1_valid_r && !advance;
  assign in_accept = in_valid && !in_stall;

  always_comb begin
    if (in_accept) begin
      s1_valid_nxt = 1'b1;
    end else if (advance) begin
      s1_valid_nxt = 1'b0;
    end else begin
      s1_valid_nxt = s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  // Capture the character of each accepted transaction.
  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_char_r <= in_char_in;
    end
  end

  ihex_parser u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (advance),
    .char_q    (s1_char_r),
    .res_valid (res_valid),
    .res       (res)
  );

  // Load a result only for characters that produce one.
  ihex_result_reg u_result (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (advance && res_valid),
    .res       (res),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_res   (out_res)
  );

  assign out_kind        = out_res.kind;
  assign out_data_byte   = out_res.data_byte;
  assign out_abs_address = out_res.abs_address;
  assign out_byte_count  = out_res.byte_count;
  assign out_record_type = out_res.record_type;
  assign out_checksum_ok = out_res.checksum_ok;
  assign out_error       = out_res.error;

endmodule

@@ test/intel_hex_record_decoder_test.sv @@
// Self-checking bench for intel_hex_record_decoder: random Intel HEX text in,
// decoded bytes and record ends out, checked against an in-bench decoder model.
// Depends on ihex_pkg and the intel_hex_record_decoder RTL.
module intel_hex_record_decoder_test;
  import ihex_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // Record types the package does not name
  localparam logic [7:0] REC_EOF       = 8'h01;
  localparam logic [7:0] REC_START_SEG = 8'h03;
  localparam logic [7:0] REC_START_LIN = 8'h05;

  // Line breaks that separate records in a real file
  localparam logic [7:0] CHAR_RETURN  = 8'h0D;
  localparam logic [7:0] CHAR_NEWLINE = 8'h0A;

  localparam int RESET_CYCLES  = 12;
  localparam int RECORD_CHARS  = 1150; // characters inside records, random part
  localparam int CALM_TAIL     = 200;  // last characters sent with no idling
  localparam int SETTLE_CYCLES = 10;   // wait for stray extra results after the last one
  localparam int STUCK_LIMIT   = 2000;

  typedef struct packed {
    logic [7:0] ch;
    logic       drain;  // hold this character until all results are back
  } text_char_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_char_in = 8'h00;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        out_kind;
  logic [7:0]  out_data_byte;
  logic [31:0] out_abs_address;
  logic [7:0]  out_byte_count;
  logic [7:0]  out_record_type;
  logic        out_checksum_ok;
  logic        out_error;

  intel_hex_record_decoder dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_char_in      (in_char_in),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_kind        (out_kind),
    .out_data_byte   (out_data_byte),
    .out_abs_address (out_abs_address),
    .out_byte_count  (out_byte_count),
    .out_record_type (out_record_type),
    .out_checksum_ok (out_checksum_ok),
    .out_error       (out_error)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Text still to send, and decoded results still owed by the block
  text_char_t hex_text_q[$];
  result_t    decoded_q[$];
  int         fail_count = 0;
  int         live_chars = 0;

  // Decoder state of the model, reset once with the block
  logic       rec_open = 1'b0;
  logic [9:0] digit_pos = '0;
  logic [3:0] hi_nib = '0;
  logic [7:0] cnt_q = '0;
  logic [15:0] ofs_q = '0;
  logic [7:0] typ_q = '0;
  logic [15:0] base_q = '0;
  base_mode_t mode_q = BASE_NONE;
  logic [7:0] sum_q = '0;
  logic [15:0] lead_q = '0;

  // Print one line per mismatch and count every one
  task automatic flag_mismatch(input string what, input logic [31:0] got,
                               input logic [31:0] want);
    $display("%0t ns: %s got %0h expected %0h", $time, what, got, want);
    fail_count++;
  endtask

  // Nibble value of a hex digit, or -1 for anything else
  function automatic int hex_nibble(input logic [7:0] c);
    if (c >= CHAR_0 && c <= CHAR_9) return int'(c - CHAR_0);
    if (c >= CHAR_UA && c <= CHAR_UF) return int'(c - CHAR_UA) + HEX_TEN;
    if (c >= CHAR_LA && c <= CHAR_LF) return int'(c - CHAR_LA) + HEX_TEN;
    return -1;
  endfunction

  function automatic logic [31:0] record_start();
    case (mode_q)
      BASE_SEGMENT: return {12'h000, base_q, 4'h0} + {16'h0000, ofs_q};
      BASE_LINEAR:  return {base_q, ofs_q};
      default:      return {16'h0000, ofs_q};
    endcase
  endfunction

  // Advance the model by one character; return 1 when it yields a result
  function automatic bit decode_char(input logic [7:0] c, output result_t r);
    int         nib;
    logic [7:0] b;
    logic [8:0] idx;
    logic [8:0] pos;
    r = '0;
    if (!rec_open) begin
      if (c == CHAR_COLON) begin
        rec_open  = 1'b1;
        digit_pos = '0;
        hi_nib    = '0;
        cnt_q     = '0;
        ofs_q     = '0;
        typ_q     = '0;
        sum_q     = '0;
        lead_q    = '0;
      end
      return 1'b0;
    end
    r.byte_count  = cnt_q;
    r.record_type = typ_q;
    nib = hex_nibble(c);
    // Any non-hex character, a colon included, closes the record as an error
    if (nib < 0) begin
      rec_open      = 1'b0;
      r.kind        = KIND_END;
      r.abs_address = record_start();
      r.error       = 1'b1;
      return 1'b1;
    end
    if (!digit_pos[0]) begin
      hi_nib    = nib[3:0];
      digit_pos = digit_pos + 10'd1;
      return 1'b0;
    end
    b         = {hi_nib, nib[3:0]};
    idx       = digit_pos[9:1];
    digit_pos = digit_pos + 10'd1;
    sum_q     = sum_q + b;
    if (idx == IDX_COUNT) begin
      cnt_q = b;
    end else if (idx == IDX_OFS_HI) begin
      ofs_q[15:8] = b;
    end else if (idx == IDX_OFS_LO) begin
      ofs_q[7:0] = b;
    end else if (idx == IDX_TYPE) begin
      typ_q = b;
    end else if (idx < IDX_DATA + {1'b0, cnt_q}) begin
      pos = idx - IDX_DATA;
      // The first two data bytes are the base, big-endian
      if (pos == 9'd0) lead_q[15:8] = b;
      else if (pos == 9'd1) lead_q[7:0] = b;
      if (typ_q == REC_DATA) begin
        r.kind        = KIND_DATA;
        r.data_byte   = b;
        r.abs_address = record_start() + {23'd0, pos};
        r.byte_count  = cnt_q;
        r.record_type = typ_q;
        return 1'b1;
      end
    end else begin
      // Checksum byte: close the record, load the base on a good checksum
      rec_open      = 1'b0;
      r.kind        = KIND_END;
      r.abs_address = record_start();
      r.byte_count  = cnt_q;
      r.record_type = typ_q;
      r.checksum_ok = (sum_q == 8'h00);
      if (r.checksum_ok && typ_q == REC_SEGMENT) begin
        base_q = lead_q;
        mode_q = BASE_SEGMENT;
      end else if (r.checksum_ok && typ_q == REC_LINEAR) begin
        base_q = lead_q;
        mode_q = BASE_LINEAR;
      end
      return 1'b1;
    end
    return 1'b0;
  endfunction

  // ---------------------------------------------------------------------
  // Stimulus building
  // ---------------------------------------------------------------------
  task automatic put_char(input logic [7:0] c, input bit drain);
    text_char_t t;
    t.ch    = c;
    t.drain = drain;
    hex_text_q.push_back(t);
  endtask

  // Hex digit in random letter case
  function automatic logic [7:0] hex_char(input logic [3:0] n);
    if (n < 4'd10) return CHAR_0 + {4'h0, n};
    return ($urandom_range(0, 1) ? CHAR_UA : CHAR_LA) + {4'h0, n} - HEX_TEN;
  endfunction

  // Character that breaks a record: often a stray colon
  function automatic logic [7:0] pick_non_hex();
    logic [7:0] c;
    if ($urandom_range(0, 3) == 0) return CHAR_COLON;
    do c = 8'($urandom); while (hex_nibble(c) >= 0);
    return c;
  endfunction

  // Text between records: mostly line breaks, sometimes any byte but a colon
  task automatic put_gap();
    logic [7:0] c;
    int         n;
    if ($urandom_range(0, 3) == 0) begin
      n = $urandom_range(1, 3);
      repeat (n) begin
        do c = 8'($urandom); while (c == CHAR_COLON);
        put_char(c, 1'b0);
      end
    end else begin
      put_char(CHAR_RETURN, 1'b0);
      put_char(CHAR_NEWLINE, 1'b0);
    end
  endtask

  // Queue one record. Lead holds the first two data bytes, the rest is
  // random. A cut of zero or more replaces that digit with a non-hex char.
  task automatic add_record(input logic [7:0] cnt, input logic [15:0] ofs,
                            input logic [7:0] rtype, input logic [15:0] lead,
                            input bit bad_sum, input int cut, input bit drain);
    logic [7:0] rec_bytes[$];
    logic [7:0] total;
    int         ndig;
    rec_bytes = {cnt, ofs[15:8], ofs[7:0], rtype};
    for (int i = 0; i < cnt; i++)
      rec_bytes.push_back(i == 0 ? lead[15:8] : i == 1 ? lead[7:0] : 8'($urandom));
    total = '0;
    foreach (rec_bytes[i]) total += rec_bytes[i];
    total = -total;
    if (bad_sum) total = total + 8'($urandom_range(1, 255));
    rec_bytes.push_back(total);
    put_char(CHAR_COLON, drain);
    live_chars++;
    ndig = 0;
    foreach (rec_bytes[i]) begin
      for (int h = 1; h >= 0; h--) begin
        live_chars++;
        if (ndig == cut) begin
          put_char(pick_non_hex(), 1'b0);
          return;
        end
        put_char(hex_char(h ? rec_bytes[i][7:4] : rec_bytes[i][3:0]), 1'b0);
        ndig++;
      end
    end
  endtask

  task automatic random_record();
    logic [7:0]  rtype;
    logic [7:0]  cnt;
    logic [15:0] ofs;
    logic [15:0] lead;
    int          sel;
    int          cut;
    sel = $urandom_range(0, 9);
    case (sel)
      6:       rtype = REC_SEGMENT;
      7:       rtype = REC_LINEAR;
      8:       rtype = ($urandom_range(0, 2) == 0) ? REC_EOF :
                       ($urandom_range(0, 1) ? REC_START_SEG : REC_START_LIN);
      9:       rtype = 8'($urandom);
      default: rtype = REC_DATA;
    endcase
    if (rtype == REC_SEGMENT || rtype == REC_LINEAR) cnt = 8'($urandom_range(0, 3));
    else if ($urandom_range(0, 59) == 0) cnt = 8'($urandom_range(32, 255));
    else cnt = 8'($urandom_range(0, 16));
    case ($urandom_range(0, 7))
      0:       ofs = 16'hFFFF;
      1:       ofs = 16'h0000;
      default: ofs = 16'($urandom);
    endcase
    lead = ($urandom_range(0, 5) == 0) ? 16'hFFFF : 16'($urandom);
    // Roughly one record in ten is broken off by a stray character
    cut = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 2 * cnt + 9) : -1;
    add_record(cnt, ofs, rtype, lead, $urandom_range(0, 7) == 0, cut,
               $urandom_range(0, 39) == 0);
  endtask

  // ---------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------
  initial begin
    // Ignored text outside a record, field extremes included
    put_char(CHAR_RETURN, 1'b0);
    put_char(8'hFF, 1'b0);
    put_char(8'h00, 1'b0);
    put_char(hex_char(4'hA), 1'b0);
    // End-of-file record, then a linear base of FFFF
    add_record(8'd0, 16'h0000, REC_EOF, 16'h0000, 1'b0, -1, 1'b0);
    add_record(8'd2, 16'h0000, REC_LINEAR, 16'hFFFF, 1'b0, -1, 1'b0);
    // Data at the top of the space: addresses wrap past FFFFFFFF
    add_record(8'd2, 16'hFFFF, REC_DATA, 16'h00FF, 1'b0, -1, 1'b0);
    // Bad checksum on a segment record leaves the base alone
    add_record(8'd1, 16'h0000, REC_SEGMENT, 16'hAB00, 1'b1, -1, 1'b0);
    // Short segment record (no data bytes), sent only once the block is empty
    add_record(8'd0, 16'hFFFF, REC_SEGMENT, 16'h0000, 1'b0, -1, 1'b1);
    // Long segment record: only the first two bytes count
    add_record(8'd3, 16'h1234, REC_SEGMENT, 16'hFFFF, 1'b0, -1, 1'b0);
    add_record(8'd1, 16'hFFFF, REC_DATA, 16'h5A00, 1'b0, -1, 1'b0);
    add_record(8'd1, 16'h0000, 8'hFF, 16'h0000, 1'b0, -1, 1'b0);
    // Non-hex digit mid-record, then a colon that closes a record in error
    add_record(8'd4, 16'h0010, REC_DATA, 16'h0000, 1'b0, 3, 1'b0);
    put_char(CHAR_COLON, 1'b0);
    put_char(CHAR_COLON, 1'b0);
    put_char(CHAR_NEWLINE, 1'b0);

    live_chars = 0;
    while (live_chars < RECORD_CHARS) begin
      put_gap();
      random_record();
    end

    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Hold until all text is in and every owed result is back
    while (hex_text_q.size() != 0 || decoded_q.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (decoded_q.size() != 0)
      flag_mismatch("results never delivered", decoded_q.size(), 0);
    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // ---------------------------------------------------------------------
  // Input side: predict at acceptance, drive the next character at negedge
  // ---------------------------------------------------------------------
  logic char_taken = 1'b0;
  int   send_gap = 0;
  logic quiet = 1'b0;  // stretch with no idling on either side

  always @(posedge clk) begin
    result_t r;
    char_taken <= 1'b0;
    if (rst_n && in_valid && !in_stall) begin
      char_taken <= 1'b1;
      void'(hex_text_q.pop_front());
      if (decode_char(in_char_in, r)) decoded_q.push_back(r);
    end
  end

  always @(negedge clk) begin
    if (!rst_n || (in_valid && !char_taken)) begin
      // hold: still in reset, or the current transaction is stalled
    end else if (send_gap > 0) begin
      in_valid <= 1'b0;
      send_gap <= send_gap - 1;
    end else if (hex_text_q.size() == 0) begin
      in_valid <= 1'b0;
    end else if (hex_text_q[0].drain && decoded_q.size() != 0) begin
      // pause until the block has handed back everything it owes
      in_valid <= 1'b0;
    end else if (hex_text_q.size() > CALM_TAIL && !quiet &&
                 $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      send_gap <= $urandom_range(0, 5);
    end else begin
      in_valid   <= 1'b1;
      in_char_in <= hex_text_q[0].ch;
    end
  end

  // ---------------------------------------------------------------------
  // Output side: random stall bursts, compare each result field by field
  // ---------------------------------------------------------------------
  int stall_left = 0;

  always @(negedge clk) begin
    if ($urandom_range(0, 99) == 0) quiet <= !quiet;
    if (hex_text_q.size() <= CALM_TAIL || quiet) begin
      out_stall <= 1'b0;
    end else if (stall_left > 0) begin
      out_stall  <= 1'b1;
      stall_left <= stall_left - 1;
    end else if ($urandom_range(0, 4) == 0) begin
      out_stall  <= 1'b1;
      stall_left <= $urandom_range(0, 5);
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (decoded_q.size() == 0) begin
        flag_mismatch("unexpected result, address", out_abs_address, 0);
      end else begin
        want = decoded_q.pop_front();
        if (out_kind !== want.kind)
          flag_mismatch("kind", 32'(out_kind), 32'(want.kind));
        if (out_data_byte !== want.data_byte)
          flag_mismatch("data_byte", 32'(out_data_byte), 32'(want.data_byte));
        if (out_abs_address !== want.abs_address)
          flag_mismatch("abs_address", out_abs_address, want.abs_address);
        if (out_byte_count !== want.byte_count)
          flag_mismatch("byte_count", 32'(out_byte_count), 32'(want.byte_count));
        if (out_record_type !== want.record_type)
          flag_mismatch("record_type", 32'(out_record_type), 32'(want.record_type));
        if (out_checksum_ok !== want.checksum_ok)
          flag_mismatch("checksum_ok", 32'(out_checksum_ok), 32'(want.checksum_ok));
        if (out_error !== want.error)
          flag_mismatch("error", 32'(out_error), 32'(want.error));
      end
    end
  end

  // Drop the run if neither channel moves a transaction for too long
  int stuck_cycles = 0;

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      stuck_cycles <= 0;
    end else if (stuck_cycles >= STUCK_LIMIT) begin
      $display("no transaction for %0d cycles", STUCK_LIMIT);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

endmodule

@@ sim.f @@
sv/ihex_pkg.sv
sv/ihex_parser.sv
sv/ihex_result_reg.sv
sv/intel_hex_record_decoder.sv
test/intel_hex_record_decoder_test.sv
